// ===== hdl/sphk_pkg.sv =====
// Package for the SPH kernel height estimator: payload structs, register codes,
// sequencer state type and fixed-point constants. No dependencies.
`default_nettype none

package sphk_pkg;

   localparam int unsigned DataW   = 32;
   localparam int unsigned AccW    = 64;
   localparam int unsigned CsrIdxW = 8;
   localparam int unsigned QDepth  = 2;
   localparam int unsigned QPtrW   = $clog2(QDepth);
   localparam int unsigned QCntW   = $clog2(QDepth + 1);
   localparam int unsigned DivSteps = 80;
   localparam int unsigned DivCntW  = $clog2(DivSteps);

   localparam logic [CsrIdxW-1:0] CSR_RADIUS_SQ    = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CSR_REST_DENSITY = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] CSR_HEIGHT_SCALE = CsrIdxW'(2);
   localparam logic [CsrIdxW-1:0] CSR_HEIGHT_OFFS  = CsrIdxW'(3);

   localparam logic [DataW-1:0] RADIUS_SQ_RST    = 32'h0001_0000;
   localparam logic [DataW-1:0] REST_DENSITY_RST = 32'h0001_0000;
   localparam logic [DataW-1:0] HEIGHT_SCALE_RST = 32'h0001_0000;
   localparam logic [DataW-1:0] HEIGHT_OFFS_RST  = 32'h0000_0000;

   localparam logic [AccW-1:0]  SAT64      = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [AccW-1:0]  AVG_LIMIT  = 64'h0000_0000_FFFF_FFFF;
   localparam logic [AccW-1:0]  RAT_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [AccW-1:0]  POS_MAX    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [AccW-1:0]  NEG_MAX    = 64'h0000_0000_8000_0000;
   localparam logic [DataW-1:0] ONE_STEP   = 32'h0000_0001;

   typedef struct packed {
      logic signed [DataW-1:0] point_x;
      logic signed [DataW-1:0] point_y;
      logic signed [DataW-1:0] particle_x;
      logic signed [DataW-1:0] particle_y;
      logic        [DataW-1:0] particle_density;
      logic                    particle_present;
      logic                    last_particle;
   } sphk_req_type;

   typedef struct packed {
      logic signed [DataW-1:0] height;
      logic                    height_valid;
   } sphk_rsp_type;

   typedef struct packed {
      logic        [DataW-1:0] kernel_radius_sq;
      logic        [DataW-1:0] rest_density;
      logic signed [DataW-1:0] height_scale;
      logic signed [DataW-1:0] height_offset;
   } sphk_cfg_type;

   // queued item: distance magnitudes already formed by the front end
   typedef struct packed {
      logic [DataW-1:0] ax;
      logic [DataW-1:0] ay;
      logic [DataW-1:0] density;
      logic             present;
      logic             last;
   } sphk_item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_CMP, ST_MHI, ST_MLO, ST_MCMB,
      ST_ACC, ST_FIN, ST_DIV, ST_TERM, ST_OUT
   } sphk_state_type;

   typedef enum logic [1:0] {
      STEP_SQ, STEP_W, STEP_DW, STEP_HGT
   } sphk_step_type;

endpackage

`default_nettype wire

// ===== hdl/sphk_front.sv =====
// Front end: accepts request items, forms |dx| and |dy|, and queues them.
// Depends on sphk_pkg.
`default_nettype none

module sphk_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  sphk_pkg::sphk_req_type req_data,
   output logic                  q_valid,
   output sphk_pkg::sphk_item_type q_item,
   input  wire                   q_pop
);
   import sphk_pkg::*;

   sphk_item_type         slot_ff [QDepth];
   logic [QPtrW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0]      count_ff, count_in;
   logic                  push;
   logic signed [DataW:0] dx, dy;
   sphk_item_type         item_in;

   always_comb begin
      dx = {req_data.point_x[DataW-1], req_data.point_x}
         - {req_data.particle_x[DataW-1], req_data.particle_x};
      dy = {req_data.point_y[DataW-1], req_data.point_y}
         - {req_data.particle_y[DataW-1], req_data.particle_y};
      item_in.ax      = dx[DataW] ? DataW'(-dx) : dx[DataW-1:0];
      item_in.ay      = dy[DataW] ? DataW'(-dy) : dy[DataW-1:0];
      item_in.density = req_data.particle_density;
      item_in.present = req_data.particle_present;
      item_in.last    = req_data.last_particle;
   end

   assign req_ready = (count_ff != QCntW'(QDepth));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign count_in  = count_ff + QCntW'(push) - QCntW'(q_pop && q_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPtrW'(1);
         end
         if (q_pop && q_valid) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sphk_back.sv =====
// Back end: sequencer with one shared 32x32 multiplier and a bit-serial divider;
// accumulates kernel weights and forms the height. Depends on sphk_pkg.
`default_nettype none

module sphk_back (
   input  wire                    clock,
   input  wire                    reset,
   input  sphk_pkg::sphk_cfg_type  cfg,
   input  wire                    q_valid,
   input  sphk_pkg::sphk_item_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output sphk_pkg::sphk_rsp_type  rsp_data
);
   import sphk_pkg::*;

   sphk_state_type    state_ff, state_in;
   sphk_step_type     step_ff;
   sphk_item_type     cur_ff;
   logic [AccW-1:0]   sx_ff, sy_ff, d2_ff, mac_a_ff, hi_ff, lo_ff, w_ff;
   logic [AccW-1:0]   wds_ff, ws_ff;
   logic [AccW-1:0]   num_ff, den_ff, rem_ff, quo_ff;
   logic [DataW-1:0]  mul_b_ff;
   logic              ovf_ff, over_ff, div2_ff, neg_ff;
   logic [DivCntW-1:0] cnt_ff;
   sphk_rsp_type      res_ff, rsp_data_ff;
   logic              rsp_valid_ff;

   logic [DataW-1:0]  mul_x, mul_y;
   logic [AccW-1:0]   prod, mres, r2, skip_diff;
   logic [AccW:0]     mac_sum, d2_sum, wds_sum, ws_sum;
   logic              skip, out_free;
   logic [AccW-1:0]   rs, rem_n, quo_n, limit, div_res, m_neg;
   logic              qb, over_n;
   logic signed [AccW-1:0] t;
   logic [DataW-1:0]  smag;

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_SQX:  begin mul_x = cur_ff.ax;              mul_y = cur_ff.ax; end
         ST_SQY:  begin mul_x = cur_ff.ay;              mul_y = cur_ff.ay; end
         ST_MHI:  begin mul_x = mac_a_ff[AccW-1:DataW]; mul_y = mul_b_ff;  end
         default: begin mul_x = mac_a_ff[DataW-1:0];    mul_y = mul_b_ff;  end
      endcase
      prod = AccW'(mul_x) * AccW'(mul_y);
   end

   // floor(a*b/2^16) with saturation, from the two partial products
   always_comb begin
      mac_sum = {1'b0, hi_ff[47:0], 16'b0} + {17'b0, lo_ff[AccW-1:16]};
      mres    = (hi_ff[AccW-1:48] != '0 || mac_sum[AccW]) ? SAT64 : mac_sum[AccW-1:0];
      m_neg   = (mres > NEG_MAX) ? NEG_MAX : mres;
   end

   always_comb begin
      d2_sum    = {1'b0, sx_ff} + {1'b0, sy_ff};
      r2        = {16'b0, cfg.kernel_radius_sq, 16'b0};
      skip      = ovf_ff || (d2_ff >= r2);
      skip_diff = r2 - d2_ff;
      wds_sum   = {1'b0, wds_ff} + {1'b0, mac_a_ff};
      ws_sum    = {1'b0, ws_ff} + {1'b0, w_ff};
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   // one restoring division step: r = 2r + bit, subtract when it fits
   always_comb begin
      limit  = div2_ff ? RAT_LIMIT : AVG_LIMIT;
      rs     = {rem_ff[AccW-2:0], num_ff[AccW-1]};
      qb     = rem_ff[AccW-1] || (rs >= den_ff);
      rem_n  = qb ? rs - den_ff : rs;
      quo_n  = over_ff ? quo_ff : {quo_ff[AccW-2:0], qb};
      over_n = over_ff || (quo_n > limit);
      div_res = over_n ? limit : quo_n;
   end

   always_comb begin
      t    = $signed(quo_ff) + AccW'(cfg.height_offset);
      smag = cfg.height_scale[DataW-1] ? DataW'(-cfg.height_scale) : cfg.height_scale;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.present) begin
                  state_in = ST_SQX;
               end else if (q_item.last) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_CMP;
         ST_CMP: begin
            if (!skip) begin
               state_in = ST_MHI;
            end else if (cur_ff.last) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MHI:  state_in = ST_MLO;
         ST_MLO:  state_in = ST_MCMB;
         ST_MCMB: begin
            case (step_ff)
               STEP_DW:  state_in = ST_ACC;
               STEP_HGT: state_in = ST_OUT;
               default:  state_in = ST_MHI;
            endcase
         end
         ST_ACC:  state_in = cur_ff.last ? ST_FIN : ST_IDLE;
         ST_FIN:  state_in = (ws_ff == '0) ? ST_OUT : ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '0 && div2_ff) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: state_in = ST_MHI;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop = (state_ff == ST_IDLE) && q_valid;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wds_ff       <= '0;
         ws_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_ACC) begin
            wds_ff <= wds_sum[AccW] ? SAT64 : wds_sum[AccW-1:0];
            ws_ff  <= ws_sum[AccW] ? SAT64 : ws_sum[AccW-1:0];
         end else if (state_ff == ST_FIN) begin
            wds_ff <= '0;
            ws_ff  <= '0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: cur_ff <= q_item;
         ST_SQX:  sx_ff  <= prod;
         ST_SQY:  sy_ff  <= prod;
         ST_SUM: begin
            d2_ff  <= d2_sum[AccW-1:0];
            ovf_ff <= d2_sum[AccW];
         end
         ST_CMP: begin
            mac_a_ff <= {32'b0, skip_diff[47:16]};
            mul_b_ff <= skip_diff[47:16];
            step_ff  <= STEP_SQ;
         end
         ST_MHI:  hi_ff <= prod;
         ST_MLO:  lo_ff <= prod;
         ST_MCMB: begin
            case (step_ff)
               STEP_SQ: begin
                  mac_a_ff <= mres;
                  step_ff  <= STEP_W;
               end
               STEP_W: begin
                  w_ff     <= mres;
                  mac_a_ff <= mres;
                  mul_b_ff <= cur_ff.density;
                  step_ff  <= STEP_DW;
               end
               STEP_DW: mac_a_ff <= mres;
               default: begin
                  res_ff.height_valid <= 1'b1;
                  if (!neg_ff) begin
                     res_ff.height <= (mres > POS_MAX) ? POS_MAX[DataW-1:0] : mres[DataW-1:0];
                  end else begin
                     res_ff.height <= -m_neg[DataW-1:0];
                  end
               end
            endcase
         end
         ST_FIN: begin
            res_ff.height       <= '0;
            res_ff.height_valid <= 1'b0;
            num_ff  <= wds_ff;
            den_ff  <= ws_ff;
            rem_ff  <= '0;
            quo_ff  <= '0;
            over_ff <= 1'b0;
            div2_ff <= 1'b0;
            cnt_ff  <= DivCntW'(DivSteps - 1);
         end
         ST_DIV: begin
            if (cnt_ff != '0) begin
               num_ff  <= {num_ff[AccW-2:0], 1'b0};
               rem_ff  <= rem_n;
               quo_ff  <= quo_n;
               over_ff <= over_n;
               cnt_ff  <= cnt_ff - DivCntW'(1);
            end else if (!div2_ff) begin
               // average done; divide it by the rest density next
               num_ff  <= div_res;
               den_ff  <= (cfg.rest_density == '0) ? AccW'(ONE_STEP)
                                                    : AccW'(cfg.rest_density);
               rem_ff  <= '0;
               quo_ff  <= '0;
               over_ff <= 1'b0;
               div2_ff <= 1'b1;
               cnt_ff  <= DivCntW'(DivSteps - 1);
            end else begin
               quo_ff <= div_res;
            end
         end
         ST_TERM: begin
            mac_a_ff <= t[AccW-1] ? AccW'(-t) : AccW'(t);
            mul_b_ff <= smag;
            neg_ff   <= t[AccW-1] ^ cfg.height_scale[DataW-1];
            step_ff  <= STEP_HGT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_data_ff <= res_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/sph_kernel_height_estimator.sv =====
// Top level of the SPH kernel height estimator: configuration registers,
// front end queue and back end sequencer. Depends on sphk_pkg, sphk_front, sphk_back.
//
//   channel | ports                          | direction
//   req     | req_valid/req_ready/req_data   | in,  one neighbour item
//   rsp     | rsp_valid/rsp_ready/rsp_data   | out, one height per last item
//   csr     | csr_valid/csr_ready/csr_index/csr_data | in, register write
//
// An empty item is popped straight from idle; a particle outside the kernel is
// dropped after the distance compare, and one inside uses the shared 32x32
// multiplier for three two-part products. A last item with a nonzero weight sum
// then runs two bit-serial divisions and a final product. Reset is synchronous
// and clears accumulators, queue and registers to their defaults. A two-entry
// queue and the output register let the input and output sides stall independently.
`default_nettype none

module sph_kernel_height_estimator (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  sphk_pkg::sphk_req_type            req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output sphk_pkg::sphk_rsp_type            rsp_data,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [sphk_pkg::CsrIdxW-1:0]      csr_index,
   input  wire [sphk_pkg::DataW-1:0]        csr_data
);
   import sphk_pkg::*;

   sphk_cfg_type  cfg_ff;
   logic          q_valid, q_pop;
   sphk_item_type q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_radius_sq <= RADIUS_SQ_RST;
         cfg_ff.rest_density     <= REST_DENSITY_RST;
         cfg_ff.height_scale     <= HEIGHT_SCALE_RST;
         cfg_ff.height_offset    <= HEIGHT_OFFS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS_SQ:    cfg_ff.kernel_radius_sq <= csr_data;
            CSR_REST_DENSITY: cfg_ff.rest_density     <= csr_data;
            CSR_HEIGHT_SCALE: cfg_ff.height_scale     <= csr_data;
            CSR_HEIGHT_OFFS:  cfg_ff.height_offset    <= csr_data;
            default: ;
         endcase
      end
   end

   sphk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   sphk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/sphk_checker.sv =====
// Port-level checks for the SPH kernel height estimator, bound to the top level.
// Depends on sphk_pkg.
`default_nettype none

module sphk_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_ready,
   input sphk_pkg::sphk_req_type       req_data,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input sphk_pkg::sphk_rsp_type       rsp_data,
   input wire                         csr_valid,
   input wire                         csr_ready
);
   import sphk_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request item dropped or changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.height_valid |-> rsp_data.height == '0)
      else $error("invalid result carries nonzero height");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind sph_kernel_height_estimator sphk_checker u_checker (.*);

`default_nettype wire

// ===== tb/sphk_height_checker.sv =====
// Checker for the SPH kernel height estimator: watches req, rsp and csr channels,
// predicts each height and compares it field by field. Depends on sphk_pkg.
`default_nettype none

module sphk_height_checker (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  wire                        req_ready,
   input  sphk_pkg::sphk_req_type     req_data,
   input  wire                        rsp_valid,
   input  wire                        rsp_ready,
   input  sphk_pkg::sphk_rsp_type     rsp_data,
   input  wire                        csr_valid,
   input  wire                        csr_ready,
   input  wire [sphk_pkg::CsrIdxW-1:0] csr_index,
   input  wire [sphk_pkg::DataW-1:0]  csr_data,
   output int                         fail_count,
   output int                         pending_heights,
   output int                         heights_seen,
   output int                         valid_heights_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import sphk_pkg::*;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic [31:0] radius_sq, rest_dens, h_scale, h_offs;
   logic [63:0] dens_weight_acc, weight_acc;
   sphk_rsp_type expected_heights[$];

   assign pending_heights = expected_heights.size();

   function automatic logic [63:0] mul_q16_sat(logic [63:0] a, logic [31:0] b);
      logic [127:0] p;
      p = (128'(a) * 128'(b)) >> 16;
      return (p[127:64] != 0) ? ALL_ONES : p[63:0];
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = 65'(a) + 65'(b);
      return s[64] ? ALL_ONES : s[63:0];
   endfunction

   // floor(num * 2^16 / den), clamped at lim
   function automatic logic [63:0] div_q16(logic [63:0] num, logic [63:0] den,
                                          logic [63:0] lim);
      logic [79:0] q;
      q = {num, 16'h0} / 80'(den);
      return (q > 80'(lim)) ? lim : q[63:0];
   endfunction

   function automatic logic [63:0] magnitude(logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   task automatic accumulate_particle(sphk_req_type r);
      logic [63:0] ax, ay, d2, r2, diff, sq, w;
      logic [64:0] s;
      ax = magnitude(64'(r.point_x) - 64'(r.particle_x));
      ay = magnitude(64'(r.point_y) - 64'(r.particle_y));
      s  = 65'(ax * ax) + 65'(ay * ay);
      r2 = 64'(radius_sq) << 16;
      if (s[64]) return;
      d2 = s[63:0];
      if (d2 >= r2) return;
      diff = (r2 - d2) >> 16;
      sq = mul_q16_sat(diff, diff[31:0]);
      w  = mul_q16_sat(sq, diff[31:0]);
      dens_weight_acc = add_sat(dens_weight_acc, mul_q16_sat(w, r.particle_density));
      weight_acc = add_sat(weight_acc, w);
   endtask

   function automatic logic [31:0] finished_height();
      logic [63:0] avg, den, ratio, m, smag;
      logic signed [63:0] t, s;
      logic neg;
      avg = div_q16(dens_weight_acc, weight_acc, 64'hFFFF_FFFF);
      den = (rest_dens == 0) ? 64'd1 : 64'(rest_dens);
      ratio = div_q16(avg, den, ALL_ONES >> 1);
      t = $signed(ratio) + 64'($signed(h_offs));
      s = 64'($signed(h_scale));
      neg = (t < 0) != (s < 0);
      smag = magnitude(s);
      m = mul_q16_sat(magnitude(t), smag[31:0]);
      if (!neg) return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(-m);
   endfunction

   always @(posedge clock) begin
      sphk_rsp_type exp_h;
      if (reset) begin
         radius_sq <= RADIUS_SQ_RST;
         rest_dens <= REST_DENSITY_RST;
         h_scale <= HEIGHT_SCALE_RST;
         h_offs <= HEIGHT_OFFS_RST;
         dens_weight_acc = 0;
         weight_acc = 0;
         expected_heights.delete();
         fail_count <= 0;
         heights_seen <= 0;
         valid_heights_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RADIUS_SQ:    radius_sq <= csr_data;
               CSR_REST_DENSITY: rest_dens <= csr_data;
               CSR_HEIGHT_SCALE: h_scale <= csr_data;
               CSR_HEIGHT_OFFS:  h_offs <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.particle_present) accumulate_particle(req_data);
            if (req_data.last_particle) begin
               if (weight_acc != 0) begin
                  exp_h.height = finished_height();
                  exp_h.height_valid = 1'b1;
               end else begin
                  exp_h.height = '0;
                  exp_h.height_valid = 1'b0;
               end
               expected_heights = {expected_heights, exp_h};
               dens_weight_acc = 0;
               weight_acc = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            heights_seen <= heights_seen + 1;
            if (rsp_data.height_valid) valid_heights_seen <= valid_heights_seen + 1;
            if (expected_heights.size() == 0) begin
               $error("unexpected height item: height %h valid %b",
                      rsp_data.height, rsp_data.height_valid);
               fail_count <= fail_count + 1;
            end else begin
               exp_h = expected_heights.pop_front();
               if (rsp_data.height_valid !== exp_h.height_valid) begin
                  $error("height_valid mismatch: expected %b actual %b",
                         exp_h.height_valid, rsp_data.height_valid);
                  fail_count <= fail_count + 1;
               end else if (rsp_data.height !== exp_h.height) begin
                  $error("height mismatch: expected %h actual %h",
                         exp_h.height, rsp_data.height);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_sph_kernel_height_estimator.sv =====
// Testbench top for the SPH kernel height estimator: clock, reset, stimulus
// and verdict. Depends on sphk_pkg, the block and sphk_height_checker.
`default_nettype none

module tb_sph_kernel_height_estimator;
   timeunit 1ns;
   timeprecision 1ps;
   import sphk_pkg::*;

   localparam int CycleLimit = 1_500_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, rsp_ready = 1'b0, csr_valid = 1'b0;
   logic req_ready, rsp_valid, csr_ready;
   sphk_req_type req_data = '0;
   sphk_rsp_type rsp_data;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [DataW-1:0] csr_data = '0;
   int fail_count, pending_heights, heights_seen, valid_heights_seen;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_off = 0;
   int cycle_count = 0;
   int items_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sph_kernel_height_estimator i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   sphk_height_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count,
      .pending_heights, .heights_seen, .valid_heights_seen
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off counted here
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // valid stays up between items unless the sender idles
   task automatic send_item(sphk_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [DataW-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_heights != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   function automatic logic [31:0] near(logic [31:0] base, int unsigned span);
      return base + 32'($signed($urandom_range(2 * span)) - $signed(span));
   endfunction

   function automatic sphk_req_type neighbour(logic [31:0] px, logic [31:0] py,
                                              int unsigned span, logic last);
      sphk_req_type r;
      r.point_x = px;
      r.point_y = py;
      r.particle_x = near(px, span);
      r.particle_y = near(py, span);
      r.particle_density = ($urandom_range(9) == 0) ? $urandom() :
                           32'($urandom_range(32'h0004_0000));
      r.particle_present = ($urandom_range(11) != 0);
      r.last_particle = last;
      return r;
   endfunction

   // one grid point: a short neighbour list, mostly well formed
   task automatic send_grid_point(int unsigned span);
      logic [31:0] px, py;
      int n;
      sphk_req_type r;
      px = ($urandom_range(7) == 0) ? $urandom() : near(32'h0, 32'h0040_0000);
      py = ($urandom_range(7) == 0) ? $urandom() : near(32'h0, 32'h0040_0000);
      n = $urandom_range(6);
      for (int i = 0; i <= n; i++) begin
         if ($urandom_range(19) == 0) begin
            r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 2'b00};
            r.particle_present = $urandom_range(1);
            r.last_particle = (i == n);
         end else begin
            r = neighbour(px, py, span, i == n);
         end
         send_item(r);
      end
   endtask

   task automatic random_phase(int unsigned items, int unsigned span);
      int start;
      start = items_sent;
      while (items_sent - start < items) send_grid_point(span);
   endtask

   initial begin
      sphk_req_type r;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults, edge of kernel, empty items, extremes
      r = '0;
      r.particle_density = 32'h0001_0000;
      r.particle_present = 1'b1;
      send_item(r);
      r.particle_x = 32'h0000_8000;
      r.last_particle = 1'b1;
      send_item(r);
      r = '0;
      r.last_particle = 1'b1;
      send_item(r);                          // empty neighbourhood
      r.particle_present = 1'b1;
      r.particle_x = 32'h0001_0000;           // exactly on the kernel edge
      send_item(r);
      r.particle_x = 32'h0000_FFFF;           // just inside, diff below one step
      r.particle_density = 32'hFFFF_FFFF;
      send_item(r);
      r = '1;
      r.point_x = 32'h8000_0000;
      r.particle_x = 32'h7FFF_FFFF;
      send_item(r);                          // huge distance
      r = '1;
      r.particle_present = 1'b0;
      send_item(r);                          // empty item with junk fields
      drain_block();

      write_reg(CSR_RADIUS_SQ, 32'hFFFF_FFFF);
      write_reg(CSR_REST_DENSITY, 32'h0);
      write_reg(CSR_HEIGHT_SCALE, 32'h7FFF_FFFF);
      write_reg(CSR_HEIGHT_OFFS, 32'h7FFF_FFFF);
      write_reg(8'hFF, 32'h1234_5678);        // unused index
      for (int i = 0; i < 4; i++) begin
         r = '0;
         r.particle_x = 32'(i * 32'h0010_0000);
         r.particle_density = (i == 0) ? 32'hFFFF_FFFF : 32'h0000_0001;
         r.particle_present = 1'b1;
         r.last_particle = (i[0] == 1'b1);
         send_item(r);
      end
      drain_block();
      write_reg(CSR_HEIGHT_SCALE, 32'h8000_0000);
      write_reg(CSR_HEIGHT_OFFS, 32'h8000_0000);
      write_reg(CSR_REST_DENSITY, 32'hFFFF_FFFF);
      r = '0;
      r.particle_y = 32'hFFFF_0000;
      r.particle_density = 32'hFFFF_FFFF;
      r.particle_present = 1'b1;
      r.last_particle = 1'b1;
      send_item(r);
      drain_block();

      // random phases with different register settings and idling patterns
      write_reg(CSR_RADIUS_SQ, 32'h0010_0000);
      write_reg(CSR_REST_DENSITY, 32'h0001_0000);
      write_reg(CSR_HEIGHT_SCALE, 32'h0001_8000);
      write_reg(CSR_HEIGHT_OFFS, 32'hFFFF_0000);
      send_idle_pct = 21;
      recv_idle_pct = 47;
      random_phase(200, 32'h0004_0000);
      hold_off = 3000;                       // block fills and stalls its input
      random_phase(30, 32'h0004_0000);
      drain_block();                         // sender pauses until all heights are in

      write_reg(CSR_RADIUS_SQ, $urandom());
      write_reg(CSR_REST_DENSITY, $urandom() | 32'h1);
      write_reg(CSR_HEIGHT_SCALE, $urandom());
      write_reg(CSR_HEIGHT_OFFS, $urandom());
      send_idle_pct = 47;
      recv_idle_pct = 21;
      random_phase(200, 32'h0100_0000);
      drain_block();

      write_reg(CSR_RADIUS_SQ, 32'h0000_0000);
      random_phase(20, 32'h0001_0000);
      drain_block();
      write_reg(CSR_RADIUS_SQ, 32'h0040_0000);
      write_reg(CSR_REST_DENSITY, 32'h0000_4000);
      write_reg(CSR_HEIGHT_SCALE, 32'hFFFE_0000);
      write_reg(CSR_HEIGHT_OFFS, 32'h0000_8000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(200, 32'h0002_0000);

      drain_block();
      $display("sent %0d neighbour items, checked %0d heights (%0d valid)",
               items_sent, heights_seen, valid_heights_seen);
      $display("covered kernel edge, empty lists, saturation and register extremes");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
